// ===== design/xice_pkg.sv =====
// Package for the instruction clock estimator: payload structs, class codes,
// and the queue entry passed between front and back. No dependencies.
`timescale 1ns / 1ps

package xice_pkg;

	localparam int REP_COUNT_BITS = 16;

	typedef enum logic [5:0] {
		C_SIMPLE = 6'd0, C_ASCII = 6'd1, C_CWD = 6'd2, C_AAD = 6'd3, C_AAM = 6'd4,
		C_ALU = 6'd5, C_CALL = 6'd6, C_CMP = 6'd7, C_CMPS = 6'd8, C_INCDEC = 6'd9,
		C_DIV = 6'd10, C_ESC = 6'd11, C_IDIV = 6'd12, C_IMUL = 6'd13, C_IN = 6'd14,
		C_INT = 6'd15, C_INT3 = 6'd16, C_INTO = 6'd17, C_IRET = 6'd18, C_JCC = 6'd19,
		C_JCXZ = 6'd20, C_JMP = 6'd21, C_LDS = 6'd22, C_LEA = 6'd23, C_LODS = 6'd24,
		C_LOOP = 6'd25, C_LOOPZ = 6'd26, C_LOOPNZ = 6'd27, C_MOV = 6'd28,
		C_MOVS = 6'd29, C_MUL = 6'd30, C_NEG = 6'd31, C_OUT = 6'd32, C_POP = 6'd33,
		C_POPF = 6'd34, C_PUSH = 6'd35, C_PUSHF = 6'd36, C_RET = 6'd37,
		C_RETF = 6'd38, C_SHIFT = 6'd39, C_SCAS = 6'd40, C_STOS = 6'd41,
		C_TEST = 6'd42, C_WAIT = 6'd43, C_XCHG = 6'd44, C_XLAT = 6'd45
	} cmd_t;

	localparam logic [1:0] K_REG = 2'd1;
	localparam logic [1:0] K_MEM = 2'd2;
	localparam logic [1:0] K_IMM = 2'd3;

	typedef struct packed {
		logic [5:0]  cmd;
		logic [1:0]  first_kind;
		logic [1:0]  second_kind;
		logic        wide;
		logic        far;
		logic [1:0]  ea_mode;
		logic        has_displacement;
		logic        segment_override;
		logic        branch_taken;
		logic [15:0] rep_count;
		logic [7:0]  shift_count;
		logic        address_unaligned;
	} in_item_t;

	typedef struct packed {
		logic [20:0] min_clocks;
		logic [20:0] max_clocks;
		logic [16:0] transfers;
	} out_item_t;

	// Row kinds for the scaled terms computed in the back part.
	typedef enum logic [1:0] {
		SC_NONE, SC_REP, SC_CL
	} scale_t;

	// Classified transaction: base row plus the scaled term and extras.
	typedef struct packed {
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [2:0]  xfers;
		scale_t      scale;
		logic [4:0]  mult;
		logic [1:0]  xmult;
		logic [15:0] count;
		logic [3:0]  ea;
		logic        align;
	} entry_t;

endpackage

// ===== design/xice_front.sv =====
// Front part: classifies one instruction into a base row, scaled term and EA extras.
// Depends on xice_pkg.
`timescale 1ns / 1ps

module xice_front (
	input  xice_pkg::in_item_t d,
	input  logic               assume_8088,
	output xice_pkg::entry_t   e
);

	logic r0, r1, m0, m1, i0, i1;
	logic [7:0] lo, hi;
	logic [2:0] xf;
	logic use_ea;
	logic [4:0] ea_full;
	logic [15:0] rep;
	xice_pkg::scale_t scale;
	logic [4:0] mult;
	logic [1:0] xmult;
	logic [15:0] count;

	assign r0 = d.first_kind == xice_pkg::K_REG;
	assign r1 = d.second_kind == xice_pkg::K_REG;
	assign m0 = d.first_kind == xice_pkg::K_MEM;
	assign m1 = d.second_kind == xice_pkg::K_MEM;
	assign i0 = d.first_kind == xice_pkg::K_IMM;
	assign i1 = d.second_kind == xice_pkg::K_IMM;
	assign rep = d.rep_count & 16'((17'd1 << xice_pkg::REP_COUNT_BITS) - 17'd1);

	always_comb begin
		lo = '0; hi = '0; xf = '0; use_ea = 1'b0;
		scale = xice_pkg::SC_NONE; mult = '0; xmult = '0; count = rep;
		case (d.cmd)
			xice_pkg::C_SIMPLE: begin lo = 8'd2; hi = 8'd2; end
			xice_pkg::C_ASCII: begin lo = 8'd4; hi = 8'd4; end
			xice_pkg::C_CWD: begin lo = 8'd5; hi = 8'd5; end
			xice_pkg::C_AAD: begin lo = 8'd60; hi = 8'd60; end
			xice_pkg::C_AAM: begin lo = 8'd83; hi = 8'd83; end
			xice_pkg::C_ALU, xice_pkg::C_CMP: begin
				if (r0 && r1) begin lo = 8'd3; hi = 8'd3; end
				if (r0 && m1) begin lo = 8'd9; hi = 8'd9; xf = 3'd1; use_ea = 1'b1; end
				if (m0 && r1) begin
					if (d.cmd == xice_pkg::C_ALU) begin lo = 8'd16; hi = 8'd16; xf = 3'd2; end
					else begin lo = 8'd9; hi = 8'd9; xf = 3'd1; end
					use_ea = 1'b1;
				end
				if (r0 && i1) begin lo = 8'd4; hi = 8'd4; end
				if (m0 && i1) begin
					if (d.cmd == xice_pkg::C_ALU) begin lo = 8'd17; hi = 8'd17; xf = 3'd2; end
					else begin lo = 8'd10; hi = 8'd10; xf = 3'd1; end
					use_ea = 1'b1;
				end
			end
			xice_pkg::C_CALL: begin
				if (m0) begin
					if (d.far) begin lo = 8'd37; hi = 8'd37; xf = 3'd4; end
					else begin lo = 8'd21; hi = 8'd21; xf = 3'd2; end
					use_ea = 1'b1;
				end else if (r0) begin lo = 8'd16; hi = 8'd16; xf = 3'd1; end
				else if (d.far) begin lo = 8'd28; hi = 8'd28; xf = 3'd2; end
				else begin lo = 8'd19; hi = 8'd19; xf = 3'd1; end
			end
			xice_pkg::C_CMPS: begin
				if (rep != 0) begin
					lo = 8'd9; hi = 8'd9; scale = xice_pkg::SC_REP; mult = 5'd22; xmult = 2'd2;
				end else begin lo = 8'd22; hi = 8'd22; xf = 3'd2; end
			end
			xice_pkg::C_MOVS: begin
				if (rep != 0) begin
					lo = 8'd9; hi = 8'd9; scale = xice_pkg::SC_REP; mult = 5'd17; xmult = 2'd2;
				end else begin lo = 8'd18; hi = 8'd18; xf = 3'd2; end
			end
			xice_pkg::C_LODS: begin
				if (rep != 0) begin
					lo = 8'd9; hi = 8'd9; scale = xice_pkg::SC_REP; mult = 5'd13; xmult = 2'd1;
				end else begin lo = 8'd12; hi = 8'd12; xf = 3'd1; end
			end
			xice_pkg::C_SCAS: begin
				if (rep != 0) begin
					lo = 8'd9; hi = 8'd9; scale = xice_pkg::SC_REP; mult = 5'd15; xmult = 2'd1;
				end else begin lo = 8'd15; hi = 8'd15; xf = 3'd1; end
			end
			xice_pkg::C_STOS: begin
				if (rep != 0) begin
					lo = 8'd9; hi = 8'd9; scale = xice_pkg::SC_REP; mult = 5'd10; xmult = 2'd1;
				end else begin lo = 8'd11; hi = 8'd11; xf = 3'd1; end
			end
			xice_pkg::C_WAIT: begin
				lo = 8'd3; hi = 8'd3; scale = xice_pkg::SC_REP; mult = 5'd5;
			end
			xice_pkg::C_INCDEC: begin
				if (r0) begin lo = d.wide ? 8'd2 : 8'd3; hi = lo; end
				if (m0) begin lo = 8'd15; hi = 8'd15; xf = 3'd2; use_ea = 1'b1; end
			end
			xice_pkg::C_DIV: begin
				if (r0) begin lo = d.wide ? 8'd144 : 8'd80; hi = d.wide ? 8'd162 : 8'd90; end
				if (m0) begin
					lo = d.wide ? 8'd150 : 8'd86; hi = d.wide ? 8'd168 : 8'd96;
					xf = 3'd1; use_ea = 1'b1;
				end
			end
			xice_pkg::C_ESC: begin
				if (i0 && m1) begin lo = 8'd8; hi = 8'd8; xf = 3'd1; use_ea = 1'b1; end
				if (i0 && r1) begin lo = 8'd2; hi = 8'd2; end
			end
			xice_pkg::C_IDIV: begin
				if (r0) begin lo = d.wide ? 8'd165 : 8'd101; hi = d.wide ? 8'd184 : 8'd112; end
				if (m0) begin
					lo = d.wide ? 8'd171 : 8'd107; hi = d.wide ? 8'd190 : 8'd118;
					xf = 3'd1; use_ea = 1'b1;
				end
			end
			xice_pkg::C_IMUL: begin
				if (r0) begin lo = d.wide ? 8'd128 : 8'd80; hi = d.wide ? 8'd154 : 8'd98; end
				if (m0) begin
					lo = d.wide ? 8'd134 : 8'd86; hi = d.wide ? 8'd160 : 8'd104;
					xf = 3'd1; use_ea = 1'b1;
				end
			end
			xice_pkg::C_MUL: begin
				if (r0) begin lo = d.wide ? 8'd118 : 8'd70; hi = d.wide ? 8'd133 : 8'd77; end
				if (m0) begin
					lo = d.wide ? 8'd124 : 8'd76; hi = d.wide ? 8'd139 : 8'd83;
					xf = 3'd1; use_ea = 1'b1;
				end
			end
			xice_pkg::C_IN: begin
				if (r0 && i1) begin lo = 8'd10; hi = 8'd10; xf = 3'd1; end
				if (r0 && r1) begin lo = 8'd8; hi = 8'd8; xf = 3'd1; end
			end
			xice_pkg::C_OUT: begin
				if (i0 && r1) begin lo = 8'd10; hi = 8'd10; xf = 3'd1; end
				if (r0 && r1) begin lo = 8'd8; hi = 8'd8; xf = 3'd1; end
			end
			xice_pkg::C_INT: begin lo = 8'd51; hi = 8'd51; xf = 3'd5; end
			xice_pkg::C_INT3: begin lo = 8'd52; hi = 8'd52; xf = 3'd5; end
			xice_pkg::C_INTO: begin lo = 8'd4; hi = 8'd53; xf = 3'd5; end
			xice_pkg::C_IRET: begin lo = 8'd24; hi = 8'd24; xf = 3'd3; end
			xice_pkg::C_JCC: begin lo = d.branch_taken ? 8'd16 : 8'd4; hi = lo; end
			xice_pkg::C_JCXZ, xice_pkg::C_LOOPZ: begin
				lo = d.branch_taken ? 8'd18 : 8'd6; hi = lo;
			end
			xice_pkg::C_LOOP: begin lo = d.branch_taken ? 8'd17 : 8'd5; hi = lo; end
			xice_pkg::C_LOOPNZ: begin lo = d.branch_taken ? 8'd19 : 8'd5; hi = lo; end
			xice_pkg::C_JMP: begin
				if (m0) begin
					if (d.far) begin lo = 8'd24; hi = 8'd24; xf = 3'd2; end
					else begin lo = 8'd18; hi = 8'd18; xf = 3'd1; end
					use_ea = 1'b1;
				end
				if (i0) begin lo = 8'd15; hi = 8'd15; end
				if (r0) begin lo = 8'd11; hi = 8'd11; end
			end
			xice_pkg::C_LDS: begin lo = 8'd16; hi = 8'd16; xf = 3'd2; use_ea = 1'b1; end
			xice_pkg::C_LEA: begin lo = 8'd2; hi = 8'd2; use_ea = 1'b1; end
			xice_pkg::C_MOV: begin
				if (m0 && r1) begin lo = 8'd9; hi = 8'd9; xf = 3'd1; use_ea = 1'b1; end
				if (r0 && m1) begin lo = 8'd8; hi = 8'd8; xf = 3'd1; use_ea = 1'b1; end
				if (r0 && r1) begin lo = 8'd2; hi = 8'd2; end
				if (r0 && i1) begin lo = 8'd4; hi = 8'd4; end
				if (m0 && i1) begin lo = 8'd10; hi = 8'd10; xf = 3'd1; use_ea = 1'b1; end
			end
			xice_pkg::C_NEG: begin
				if (r0) begin lo = 8'd3; hi = 8'd3; end
				if (m0) begin lo = 8'd16; hi = 8'd16; xf = 3'd2; use_ea = 1'b1; end
			end
			xice_pkg::C_POP: begin
				if (r0) begin lo = 8'd8; hi = 8'd8; xf = 3'd1; end
				if (m0) begin lo = 8'd17; hi = 8'd17; xf = 3'd2; use_ea = 1'b1; end
			end
			xice_pkg::C_POPF: begin lo = 8'd8; hi = 8'd8; xf = 3'd1; end
			xice_pkg::C_PUSH: begin
				if (r0) begin lo = 8'd11; hi = 8'd11; xf = 3'd1; end
				if (m0) begin lo = 8'd16; hi = 8'd16; xf = 3'd2; use_ea = 1'b1; end
			end
			xice_pkg::C_PUSHF: begin lo = 8'd10; hi = 8'd10; xf = 3'd1; end
			xice_pkg::C_RET: begin lo = i0 ? 8'd12 : 8'd8; hi = lo; xf = 3'd1; end
			xice_pkg::C_RETF: begin lo = i0 ? 8'd17 : 8'd18; hi = lo; xf = 3'd2; end
			xice_pkg::C_SHIFT: begin
				if (r0 && i1) begin lo = 8'd2; hi = 8'd2; end
				if (r0 && r1) begin
					lo = 8'd8; hi = 8'd8; scale = xice_pkg::SC_CL; mult = 5'd4;
				end
				if (m0 && i1) begin lo = 8'd15; hi = 8'd15; xf = 3'd2; use_ea = 1'b1; end
				if (m0 && r1) begin
					lo = 8'd20; hi = 8'd20; xf = 3'd2; use_ea = 1'b1;
					scale = xice_pkg::SC_CL; mult = 5'd4;
				end
			end
			xice_pkg::C_TEST: begin
				if (r0 && r1) begin lo = 8'd3; hi = 8'd3; end
				if (r0 && m1) begin lo = 8'd9; hi = 8'd9; xf = 3'd1; use_ea = 1'b1; end
				if (r0 && i1) begin lo = 8'd5; hi = 8'd5; end
				if (m0 && i1) begin lo = 8'd11; hi = 8'd11; use_ea = 1'b1; end
			end
			xice_pkg::C_XCHG: begin
				if (m0 && r1) begin lo = 8'd17; hi = 8'd17; xf = 3'd2; use_ea = 1'b1; end
				if (r0 && r1) begin lo = 8'd4; hi = 8'd4; end
			end
			xice_pkg::C_XLAT: begin lo = 8'd11; hi = 8'd11; xf = 3'd1; end
			default: ;
		endcase
		if (scale == xice_pkg::SC_CL) count = {8'd0, d.shift_count};
	end

	always_comb begin
		case (d.ea_mode)
			2'd0: ea_full = 5'd2;
			2'd1: ea_full = 5'd5;
			2'd2: ea_full = 5'd8;
			default: ea_full = 5'd7;
		endcase
		ea_full = ea_full + (d.has_displacement ? 5'd4 : 5'd0)
			+ (d.segment_override ? 5'd2 : 5'd0);
	end

	assign e.lo = lo;
	assign e.hi = hi;
	assign e.xfers = xf;
	assign e.scale = scale;
	assign e.mult = mult;
	assign e.xmult = xmult;
	assign e.count = count;
	assign e.ea = (use_ea && (m0 || m1)) ? ea_full[3:0] : 4'd0;
	assign e.align = d.wide && (assume_8088 || d.address_unaligned);

endmodule

// ===== design/xice_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on xice_pkg.
`timescale 1ns / 1ps

module xice_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  xice_pkg::entry_t wdata,
	output logic             full,
	input  logic             rd,
	output logic             empty,
	output xice_pkg::entry_t rdata
);

	xice_pkg::entry_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !full && !(rd && !empty)) |=> !empty)
		else $error("write did not fill queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd) |=> full)
		else $error("full queue lost an entry");

endmodule

// ===== design/xice_back.sv =====
// Back part: multiplies the scaled term, adds extras, and holds results in an
// output register stage. Depends on xice_pkg.
`timescale 1ns / 1ps

module xice_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  xice_pkg::entry_t  q_data,
	output logic              q_rd,
	output logic              empty,
	input  logic              pop,
	output xice_pkg::out_item_t res
);

	logic valid_q;
	xice_pkg::out_item_t res_q;
	logic [20:0] scaled, extra, lo_s, hi_s;
	logic [16:0] xf;
	logic take;

	assign take = !q_empty && (!valid_q || pop);
	assign q_rd = take;

	always_comb begin
		scaled = '0;
		xf = {14'd0, q_data.xfers};
		if (q_data.scale != xice_pkg::SC_NONE) begin
			scaled = {5'd0, q_data.count} * {16'd0, q_data.mult};
			xf = {1'd0, q_data.count} * {15'd0, q_data.xmult} + {14'd0, q_data.xfers};
		end
		extra = {17'd0, q_data.ea} + (q_data.align ? {2'd0, xf, 2'b00} : 21'd0);
		lo_s = {13'd0, q_data.lo} + scaled + extra;
		hi_s = {13'd0, q_data.hi} + scaled + extra;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.min_clocks <= lo_s;
			res_q.max_clocks <= hi_s;
			res_q.transfers <= xf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (take) valid_q <= 1'b1;
		else if (pop) valid_q <= 1'b0;
	end

	assign empty = !valid_q;
	assign res = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(res_q)))
		else $error("waiting result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty && pop) |=> !valid_q)
		else $error("result repeated");
	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_q)
		else $error("result lost");

endmodule

// ===== design/x86_instruction_clock_estimator.sv =====
// A pushed transaction passes through the queue, then the result register, before it can be popped.
// Throughput: one instruction per cycle while the queue is not full; the front classifier is combinational.
// Full rises when the two-entry queue holds two entries not yet taken by the back part.
// Reset clears the queue, the result register valid and assume_8088 asynchronously.
// Depends on xice_pkg, xice_front, xice_queue, xice_back.
`timescale 1ns / 1ps

module x86_instruction_clock_estimator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  xice_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output xice_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);

	logic assume_8088_q;
	xice_pkg::entry_t fe, qd;
	logic q_empty, q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) assume_8088_q <= 1'b0;
		else if (cfg_we) assume_8088_q <= cfg_wdata;
	end

	xice_front u_front (.d(item), .assume_8088(assume_8088_q), .e(fe));

	xice_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(push), .wdata(fe), .full(full),
		.rd(q_rd), .empty(q_empty), .rdata(qd)
	);

	xice_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(qd), .q_rd(q_rd),
		.empty(empty), .pop(pop), .res(result)
	);

endmodule

// ===== sim/x86_instruction_clock_estimator_checker.sv =====
// Checker for the instruction clock estimator: predicts clocks and transfers per
// accepted instruction and compares each popped result. Depends on xice_pkg.
`timescale 1ns / 1ps

module x86_instruction_clock_estimator_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  xice_pkg::in_item_t  item,
	input  logic                empty,
	input  logic                pop,
	input  xice_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	output int                  errors,
	output int                  pending
);

	xice_pkg::out_item_t timings_due[$];
	logic mode_8088;

	function automatic xice_pkg::out_item_t estimate_clocks(xice_pkg::in_item_t it,
		logic m8088);
		xice_pkg::out_item_t o;
		logic r0, r1, m0, m1, i0, i1;
		logic [31:0] lo, hi, xf, ex, rep, cl, ea;
		r0 = it.first_kind == xice_pkg::K_REG; r1 = it.second_kind == xice_pkg::K_REG;
		m0 = it.first_kind == xice_pkg::K_MEM; m1 = it.second_kind == xice_pkg::K_MEM;
		i0 = it.first_kind == xice_pkg::K_IMM; i1 = it.second_kind == xice_pkg::K_IMM;
		rep = {16'd0, it.rep_count}; cl = {24'd0, it.shift_count};
		lo = 0; hi = 0; xf = 0; ea = 0;
		case (it.cmd)
			xice_pkg::C_SIMPLE: begin lo = 2; hi = 2; end
			xice_pkg::C_ASCII: begin lo = 4; hi = 4; end
			xice_pkg::C_CWD: begin lo = 5; hi = 5; end
			xice_pkg::C_AAD: begin lo = 60; hi = 60; end
			xice_pkg::C_AAM: begin lo = 83; hi = 83; end
			xice_pkg::C_ALU: begin
				if (r0 && r1) begin lo = 3; hi = 3; end
				if (r0 && m1) begin lo = 9; hi = 9; xf = 1; ea = 1; end
				if (m0 && r1) begin lo = 16; hi = 16; xf = 2; ea = 1; end
				if (r0 && i1) begin lo = 4; hi = 4; end
				if (m0 && i1) begin lo = 17; hi = 17; xf = 2; ea = 1; end
			end
			xice_pkg::C_CALL: begin
				if (m0) begin
					if (it.far) begin lo = 37; xf = 4; end
					else begin lo = 21; xf = 2; end
					ea = 1;
				end else if (r0) begin lo = 16; xf = 1; end
				else if (it.far) begin lo = 28; xf = 2; end
				else begin lo = 19; xf = 1; end
				hi = lo;
			end
			xice_pkg::C_CMP: begin
				if (r0 && r1) begin lo = 3; hi = 3; end
				if (r0 && m1) begin lo = 9; hi = 9; xf = 1; ea = 1; end
				if (m0 && r1) begin lo = 9; hi = 9; xf = 1; ea = 1; end
				if (r0 && i1) begin lo = 4; hi = 4; end
				if (m0 && i1) begin lo = 10; hi = 10; xf = 1; ea = 1; end
			end
			xice_pkg::C_CMPS: begin
				if (rep != 0) begin lo = 9 + 22 * rep; xf = 2 * rep; end
				else begin lo = 22; xf = 2; end
				hi = lo;
			end
			xice_pkg::C_INCDEC: begin
				if (r0) begin lo = it.wide ? 2 : 3; hi = lo; end
				if (m0) begin lo = 15; hi = 15; xf = 2; ea = 1; end
			end
			xice_pkg::C_DIV, xice_pkg::C_IDIV, xice_pkg::C_IMUL, xice_pkg::C_MUL: begin
				if (r0 || m0) begin
					case (it.cmd)
						xice_pkg::C_DIV: begin
							lo = it.wide ? 144 : 80; hi = it.wide ? 162 : 90;
						end
						xice_pkg::C_IDIV: begin
							lo = it.wide ? 165 : 101; hi = it.wide ? 184 : 112;
						end
						xice_pkg::C_IMUL: begin
							lo = it.wide ? 128 : 80; hi = it.wide ? 154 : 98;
						end
						default: begin lo = it.wide ? 118 : 70; hi = it.wide ? 133 : 77; end
					endcase
				end
				if (m0) begin lo += 6; hi += 6; xf = 1; ea = 1; end
			end
			xice_pkg::C_ESC: begin
				if (i0 && m1) begin lo = 8; hi = 8; xf = 1; ea = 1; end
				if (i0 && r1) begin lo = 2; hi = 2; end
			end
			xice_pkg::C_IN: begin
				if (r0 && i1) begin lo = 10; hi = 10; xf = 1; end
				if (r0 && r1) begin lo = 8; hi = 8; xf = 1; end
			end
			xice_pkg::C_INT: begin lo = 51; hi = 51; xf = 5; end
			xice_pkg::C_INT3: begin lo = 52; hi = 52; xf = 5; end
			xice_pkg::C_INTO: begin lo = 4; hi = 53; xf = 5; end
			xice_pkg::C_IRET: begin lo = 24; hi = 24; xf = 3; end
			xice_pkg::C_JCC: begin lo = it.branch_taken ? 16 : 4; hi = lo; end
			xice_pkg::C_JCXZ: begin lo = it.branch_taken ? 18 : 6; hi = lo; end
			xice_pkg::C_JMP: begin
				if (m0) begin
					if (it.far) begin lo = 24; xf = 2; end
					else begin lo = 18; xf = 1; end
					hi = lo; ea = 1;
				end
				if (i0) begin lo = 15; hi = 15; end
				if (r0) begin lo = 11; hi = 11; end
			end
			xice_pkg::C_LDS: begin lo = 16; hi = 16; xf = 2; ea = 1; end
			xice_pkg::C_LEA: begin lo = 2; hi = 2; ea = 1; end
			xice_pkg::C_LODS: begin
				if (rep != 0) begin lo = 9 + 13 * rep; xf = rep; end
				else begin lo = 12; xf = 1; end
				hi = lo;
			end
			xice_pkg::C_LOOP: begin lo = it.branch_taken ? 17 : 5; hi = lo; end
			xice_pkg::C_LOOPZ: begin lo = it.branch_taken ? 18 : 6; hi = lo; end
			xice_pkg::C_LOOPNZ: begin lo = it.branch_taken ? 19 : 5; hi = lo; end
			xice_pkg::C_MOV: begin
				if (m0 && r1) begin lo = 9; hi = 9; xf = 1; ea = 1; end
				if (r0 && m1) begin lo = 8; hi = 8; xf = 1; ea = 1; end
				if (r0 && r1) begin lo = 2; hi = 2; end
				if (r0 && i1) begin lo = 4; hi = 4; end
				if (m0 && i1) begin lo = 10; hi = 10; xf = 1; ea = 1; end
			end
			xice_pkg::C_MOVS: begin
				if (rep != 0) begin lo = 9 + 17 * rep; xf = 2 * rep; end
				else begin lo = 18; xf = 2; end
				hi = lo;
			end
			xice_pkg::C_NEG: begin
				if (r0) begin lo = 3; hi = 3; end
				if (m0) begin lo = 16; hi = 16; xf = 2; ea = 1; end
			end
			xice_pkg::C_OUT: begin
				if (i0 && r1) begin lo = 10; hi = 10; xf = 1; end
				if (r0 && r1) begin lo = 8; hi = 8; xf = 1; end
			end
			xice_pkg::C_POP: begin
				if (r0) begin lo = 8; hi = 8; xf = 1; end
				if (m0) begin lo = 17; hi = 17; xf = 2; ea = 1; end
			end
			xice_pkg::C_POPF: begin lo = 8; hi = 8; xf = 1; end
			xice_pkg::C_PUSH: begin
				if (r0) begin lo = 11; hi = 11; xf = 1; end
				if (m0) begin lo = 16; hi = 16; xf = 2; ea = 1; end
			end
			xice_pkg::C_PUSHF: begin lo = 10; hi = 10; xf = 1; end
			xice_pkg::C_RET: begin lo = i0 ? 12 : 8; hi = lo; xf = 1; end
			xice_pkg::C_RETF: begin lo = i0 ? 17 : 18; hi = lo; xf = 2; end
			xice_pkg::C_SHIFT: begin
				if (r0 && i1) begin lo = 2; hi = 2; end
				if (r0 && r1) begin lo = 8 + 4 * cl; hi = lo; end
				if (m0 && i1) begin lo = 15; hi = 15; xf = 2; ea = 1; end
				if (m0 && r1) begin lo = 20 + 4 * cl; hi = lo; xf = 2; ea = 1; end
			end
			xice_pkg::C_SCAS: begin
				if (rep != 0) begin lo = 9 + 15 * rep; xf = rep; end
				else begin lo = 15; xf = 1; end
				hi = lo;
			end
			xice_pkg::C_STOS: begin
				if (rep != 0) begin lo = 9 + 10 * rep; xf = rep; end
				else begin lo = 11; xf = 1; end
				hi = lo;
			end
			xice_pkg::C_TEST: begin
				if (r0 && r1) begin lo = 3; hi = 3; end
				if (r0 && m1) begin lo = 9; hi = 9; xf = 1; ea = 1; end
				if (r0 && i1) begin lo = 5; hi = 5; end
				if (m0 && i1) begin lo = 11; hi = 11; ea = 1; end
			end
			xice_pkg::C_WAIT: begin lo = 3 + 5 * rep; hi = lo; end
			xice_pkg::C_XCHG: begin
				if (m0 && r1) begin lo = 17; hi = 17; xf = 2; ea = 1; end
				if (r0 && r1) begin lo = 4; hi = 4; end
			end
			xice_pkg::C_XLAT: begin lo = 11; hi = 11; xf = 1; end
			default: ;
		endcase
		ex = 0;
		// Address clocks only apply when an operand actually sits in memory.
		if (ea != 0 && (m0 || m1)) begin
			case (it.ea_mode)
				2'd0: ex = 2;
				2'd1: ex = 5;
				2'd2: ex = 8;
				default: ex = 7;
			endcase
			if (it.has_displacement) ex += 4;
			if (it.segment_override) ex += 2;
		end
		if (it.wide && (m8088 || it.address_unaligned)) ex += 4 * xf;
		o.min_clocks = 21'(lo + ex);
		o.max_clocks = 21'(hi + ex);
		o.transfers = 17'(xf);
		return o;
	endfunction

	assign pending = timings_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_8088 <= 1'b0;
			errors <= 0;
			timings_due.delete();
		end else begin
			// A transaction pushed alongside a register write still sees the old
			// mode; the testbench never overlaps them anyway.
			if (push && !full)
				timings_due.push_back(estimate_clocks(item, mode_8088));
			if (cfg_we)
				mode_8088 <= cfg_wdata;
			if (pop && !empty) begin
				if (timings_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected result %h", result);
					errors <= errors + 1;
				end else begin
					if (result !== timings_due[0]) begin
						if (errors < 10)
							$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
								timings_due[0].min_clocks, timings_due[0].max_clocks,
								timings_due[0].transfers, result.min_clocks,
								result.max_clocks, result.transfers);
						errors <= errors + 1;
					end
					void'(timings_due.pop_front());
				end
			end
		end
	end

endmodule

// ===== sim/x86_instruction_clock_estimator_tb.sv =====
// Testbench top for the instruction clock estimator: drives instructions and
// mode writes, pops results at random. Depends on xice_pkg, the estimator top and the checker.
`timescale 1ns / 1ps

module x86_instruction_clock_estimator_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic full, empty;
	xice_pkg::in_item_t item = '0;
	xice_pkg::out_item_t result;
	int errors, pending;
	logic stim_done = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	x86_instruction_clock_estimator dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	x86_instruction_clock_estimator_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
	);

	function automatic xice_pkg::in_item_t random_instruction();
		xice_pkg::in_item_t it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = raw[41:0];
		it.cmd = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 9) < 8)
			it.cmd = 6'($urandom_range(0, 46));
		// Mostly short repeats to keep numbers readable; some full range.
		if ($urandom_range(0, 3) != 0)
			it.rep_count = 16'($urandom_range(0, 20));
		return it;
	endfunction

	// Push stays high across back-to-back transactions; callers drop it when done.
	task automatic send_instruction(xice_pkg::in_item_t it);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic set_mode(logic m);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int n);
		for (int i = 0; i < n; i++)
			send_instruction(random_instruction());
	endtask

	initial begin
		xice_pkg::in_item_t it;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed: every even class code with a memory first operand and a register or immediate second, extremes of counts.
		for (int c = 0; c <= 46; c += 2) begin
			it = '0;
			it.cmd = 6'(c);
			it.first_kind = xice_pkg::K_MEM;
			it.second_kind = (c % 4 == 0) ? xice_pkg::K_REG : xice_pkg::K_IMM;
			it.wide = 1'b1;
			it.ea_mode = 2'(c);
			it.has_displacement = c[1];
			it.segment_override = c[2];
			it.address_unaligned = c[3];
			it.rep_count = (c == xice_pkg::C_CMPS || c == xice_pkg::C_WAIT) ?
				16'hFFFF : 16'(c);
			it.shift_count = (c == xice_pkg::C_SHIFT + 1) ? 8'hFF : 8'(c);
			send_instruction(it);
		end
		it = '0;
		it.cmd = xice_pkg::C_SHIFT;
		it.first_kind = xice_pkg::K_MEM;
		it.second_kind = xice_pkg::K_REG;
		it.wide = 1'b1;
		it.shift_count = 8'hFF;
		it.address_unaligned = 1'b1;
		send_instruction(it);
		it.cmd = 6'h3F;
		send_instruction(it);
		run_phase(600);
		set_mode(1'b1);
		run_phase(600);
		set_mode(1'b0);
		run_phase(300);
		set_mode(1'b1);
		run_phase(325);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		stim_done = 1'b1;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin
		wait (stim_done);
		if (errors == 0 && pending == 0)
			$display("x86_instruction_clock_estimator regression: pass");
		else
			$display("x86_instruction_clock_estimator regression: fail");
		$finish;
	end

	initial begin
		#200000;
		$display("x86_instruction_clock_estimator regression: fail");
		$finish;
	end

endmodule
